// ===== design/assert_macros.svh =====
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define STC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every clock edge, reset included.
`define STC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== design/stc_pkg.sv =====
// Types, constants and codes of the session transaction cache.
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

    localparam int STC_SESSIONS     = 8;
    localparam int STC_SESSIONS_MAX = 64;
    localparam int STC_IDX_W        = $clog2(STC_SESSIONS_MAX);

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_RECORD = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] session_key;
        logic [7:0]  new_transaction_id;
    } t_in_item;

    typedef struct packed {
        logic       id_valid;
        logic [7:0] found_id;
        logic       key_present;
    } t_out_item;

    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  id;
        logic        id_ok;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic                 match_hit;
        logic                 match_ok;
        logic [7:0]           match_id;
        logic [STC_IDX_W-1:0] match_idx;
        logic                 free_hit;
        logic [STC_IDX_W-1:0] free_idx;
        logic [STC_IDX_W-1:0] min_idx;
        logic [31:0]          min_stamp;
    } t_scan_res;

endpackage

`default_nettype wire

// ===== design/stc_mem.sv =====
// Entry memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module stc_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire stc_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output stc_pkg::t_entry      o_rdata
);
    import stc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/stc_scan.sv =====
// Scan unit: finds the matching, first free and oldest entry as entries stream past.
`timescale 1ns / 1ps
`default_nettype none

module stc_scan #(
    parameter int IW = 3
) (
    input  wire logic            i_clk,
    input  wire logic            i_start,
    input  wire logic            i_dvld,
    input  wire logic [IW-1:0]   i_idx,
    input  wire logic            i_used,
    input  wire logic [31:0]     i_key,
    input  wire stc_pkg::t_entry i_entry,
    output stc_pkg::t_scan_res   o_res
);
    import stc_pkg::*;

    t_scan_res r_res;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_res.match_hit <= 1'b0;
            r_res.free_hit  <= 1'b0;
        end else if (i_dvld) begin
            if (i_used && (i_entry.key == i_key) && !r_res.match_hit) begin
                r_res.match_hit <= 1'b1;
                r_res.match_ok  <= i_entry.id_ok;
                r_res.match_id  <= i_entry.id;
                r_res.match_idx <= STC_IDX_W'(i_idx);
            end
            if (!i_used && !r_res.free_hit) begin
                r_res.free_hit <= 1'b1;
                r_res.free_idx <= STC_IDX_W'(i_idx);
            end
            if ((i_idx == '0) || (i_entry.stamp < r_res.min_stamp)) begin
                r_res.min_idx   <= STC_IDX_W'(i_idx);
                r_res.min_stamp <= i_entry.stamp;
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== design/session_transaction_cache_lru.sv =====
// Top level of the session transaction cache with oldest-stamp replacement.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+------------------------
//  input   | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  output  | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// The cache takes no new item until the last one is through: its scan reads one
// entry per cycle from the single read port of the entry memory, followed by
// a write-back state.
// Reset clears the used bits and the access counter; the entry memory needs no clearing.
// A result waiting at the output stalls the next item only at its write-back cycle.
`timescale 1ns / 1ps
`default_nettype none

module session_transaction_cache_lru #(
    parameter int SESSIONS = stc_pkg::STC_SESSIONS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire stc_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output stc_pkg::t_out_item      o_out_item
);
    import stc_pkg::*;

    localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SESSIONS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    t_in_item            r_item;
    logic [IW-1:0]       r_ptr;
    logic                r_issue;
    logic                r_dvld;
    logic [IW-1:0]       r_didx;
    logic [SESSIONS-1:0] r_used;
    logic [31:0]         r_cnt;
    logic                r_out_vld;
    t_out_item           r_out;
    t_out_item           n_out;

    logic      accept;
    logic      finish;
    logic      op_en;
    logic      we;
    logic [IW-1:0] slot;
    t_entry    wdata;
    t_entry    rdata;
    t_scan_res res;

    assign accept = i_in_valid && o_in_ready;
    assign finish = (r_state == S_WRITE) && (!r_out_vld || i_out_ready);

    stc_mem #(
        .DEPTH (SESSIONS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (slot),
        .i_wdata (wdata),
        .i_re    ((r_state == S_SCAN) && r_issue),
        .i_raddr (r_ptr),
        .o_rdata (rdata)
    );

    stc_scan #(
        .IW (IW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_start (accept),
        .i_dvld  (r_dvld),
        .i_idx   (r_didx),
        .i_used  (r_used[r_didx]),
        .i_key   (r_item.session_key),
        .i_entry (rdata),
        .o_res   (res)
    );

    always_comb begin
        op_en = (r_item.session_key != 32'd0) &&
                ((r_item.mode == MODE_LOOKUP) || (r_item.mode == MODE_RECORD) ||
                 (r_item.mode == MODE_CLEAR));
        n_out = '0;
        we    = 1'b0;
        slot  = res.match_idx[IW-1:0];
        wdata.key   = r_item.session_key;
        wdata.id    = res.match_id;
        wdata.id_ok = 1'b1;
        wdata.stamp = r_cnt + 32'd1;
        n_out.key_present = op_en && res.match_hit;
        case (r_item.mode)
            MODE_LOOKUP: begin
                if (op_en && res.match_hit && res.match_ok) begin
                    we             = finish;
                    n_out.id_valid = 1'b1;
                    n_out.found_id = res.match_id;
                end
            end
            MODE_RECORD: begin
                we       = finish && op_en;
                wdata.id = r_item.new_transaction_id;
                if (!res.match_hit) begin
                    slot = res.free_hit ? res.free_idx[IW-1:0] : res.min_idx[IW-1:0];
                end
            end
            MODE_CLEAR: begin
                we          = finish && op_en && res.match_hit;
                wdata.id    = 8'd0;
                wdata.id_ok = 1'b0;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_dvld && (r_didx == LAST)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= 1'b0;
            r_dvld    <= 1'b0;
            r_used    <= '0;
            r_cnt     <= 32'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dvld  <= (r_state == S_SCAN) && r_issue;
            if (accept) begin
                r_issue <= 1'b1;
            end else if ((r_state == S_SCAN) && r_issue && (r_ptr == LAST)) begin
                r_issue <= 1'b0;
            end
            if (we) begin
                r_used[slot] <= 1'b1;
                r_cnt        <= r_cnt + 32'd1;
            end
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
            r_ptr  <= '0;
        end else if ((r_state == S_SCAN) && r_issue && (r_ptr != LAST)) begin
            r_ptr <= r_ptr + IW'(1);
        end
        r_didx <= r_ptr;
        if (finish) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ===== design/stc_checker.sv =====
// Port checker for the session transaction cache, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire stc_pkg::t_out_item i_out_item
);
    import stc_pkg::*;

    `STC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready)
    `STC_ASSERT(a_id_zero_when_invalid, i_clk, i_rst_n, (i_out_valid && !i_out_item.id_valid) |-> (i_out_item.found_id == 8'd0))
    `STC_ASSERT(a_valid_id_needs_key, i_clk, i_rst_n, (i_out_valid && i_out_item.id_valid) |-> i_out_item.key_present)
    `STC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid)
    `STC_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_item)))

endmodule

bind session_transaction_cache_lru stc_checker u_stc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the session transaction cache with oldest-stamp replacement.
`timescale 1ns / 1ps

module testbench;
    import stc_pkg::*;

    localparam int          SLOTS        = STC_SESSIONS;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int          RANDOM_ITEMS = 1428;
    localparam int          POOL_KEYS    = 12;
    localparam int          SETTLE       = 3 * (SLOTS + 3);
    localparam int          STALL_LIMIT  = 2000;

    typedef struct packed {
        logic     drain;
        t_in_item item;
    } t_send_slot;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_send_slot pending_items[$];
    t_out_item  predicted_results[$];
    t_out_item  want;

    logic [31:0] cache_key [SLOTS];
    logic        cache_used [SLOTS];
    logic [7:0]  cache_id [SLOTS];
    logic        cache_id_ok [SLOTS];
    logic [31:0] cache_stamp [SLOTS];
    logic [31:0] touch_count;

    int send_gap = 0;
    int recv_stall = 0;
    int send_burst = 0;
    int recv_burst = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int fail_count = 0;
    int lookup_hits = 0;
    int replacements = 0;
    int present_clears = 0;
    int ignored_items = 0;

    session_transaction_cache_lru i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #10 clk = ~clk;

    function automatic int pause_len(inout int burst);
        int r;
        if (burst > 0) begin
            burst = burst - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            burst = $urandom_range(20, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic void cache_touch(int slot);
        touch_count = touch_count + 1;
        cache_stamp[slot] = touch_count;
    endfunction

    function automatic t_out_item cache_predict(t_in_item it);
        t_out_item res;
        int        hit;
        int        victim;
        res = '0;
        hit = -1;
        victim = -1;
        if (it.session_key == '0 || it.mode == MODE_UNUSED) begin
            ignored_items++;
            return res;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && cache_used[i] && cache_key[i] == it.session_key) hit = i;
        end
        res.key_present = (hit >= 0);
        case (it.mode)
            MODE_LOOKUP: begin
                if (hit >= 0 && cache_id_ok[hit]) begin
                    res.id_valid = 1'b1;
                    res.found_id = cache_id[hit];
                    cache_touch(hit);
                    lookup_hits++;
                end
            end
            MODE_RECORD: begin
                if (hit < 0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (victim < 0 && !cache_used[i]) victim = i;
                    end
                    if (victim < 0) begin
                        victim = 0;
                        for (int i = 1; i < SLOTS; i++) begin
                            if (cache_stamp[i] < cache_stamp[victim]) victim = i;
                        end
                        replacements++;
                    end
                    hit = victim;
                    cache_key[hit] = it.session_key;
                    cache_used[hit] = 1'b1;
                    cache_stamp[hit] = '0;
                end
                cache_id[hit] = it.new_transaction_id;
                cache_id_ok[hit] = 1'b1;
                cache_touch(hit);
            end
            MODE_CLEAR: begin
                if (hit >= 0) begin
                    cache_id[hit] = '0;
                    cache_id_ok[hit] = 1'b0;
                    cache_touch(hit);
                    present_clears++;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic queue_item(logic [1:0] mode, logic [31:0] key, logic [7:0] id, logic drain);
        t_send_slot s;
        s.drain = drain;
        s.item.mode = mode;
        s.item.session_key = key;
        s.item.new_transaction_id = id;
        pending_items.push_back(s);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready) begin
                predicted_results.push_back(cache_predict(in_item));
                items_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (send_gap != 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].drain && predicted_results.size() != 0)) begin
                    in_valid <= 1'b1;
                    in_item <= pending_items[0].item;
                    void'(pending_items.pop_front());
                    send_gap <= pause_len(send_burst);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (out_valid && out_ready) begin
                results_checked++;
                if (predicted_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: id_valid %0b found_id %02h key_present %0b",
                                 out_item.id_valid, out_item.found_id, out_item.key_present);
                end else begin
                    want = predicted_results.pop_front();
                    if (out_item.id_valid !== want.id_valid ||
                        out_item.found_id !== want.found_id ||
                        out_item.key_present !== want.key_present) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $write("result %0d: expected id_valid %0b found_id %02h ",
                                   results_checked, want.id_valid, want.found_id);
                            $display("key_present %0b, got %0b %02h %0b",
                                     want.key_present, out_item.id_valid,
                                     out_item.found_id, out_item.key_present);
                        end
                    end
                end
            end
            if (recv_stall != 0) begin
                out_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                out_ready <= 1'b1;
                if (out_valid && out_ready) recv_stall <= pause_len(recv_burst);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (pending_items.size() == 0 && !in_valid && predicted_results.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("session_transaction_cache_lru: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] key_pool [POOL_KEYS];
        logic [31:0] key;
        logic [1:0]  mode;
        int          pool_span;
        int          r;
        int          n;

        for (int i = 0; i < SLOTS; i++) begin
            cache_key[i] = '0;
            cache_used[i] = 1'b0;
            cache_id[i] = '0;
            cache_id_ok[i] = 1'b0;
            cache_stamp[i] = '0;
        end
        touch_count = '0;

        queue_item(MODE_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0);
        queue_item(MODE_CLEAR,  32'hFFFF_FFFF, 8'hFF, 1'b0);
        queue_item(MODE_RECORD, 32'hFFFF_FFFF, 8'hFF, 1'b0);
        queue_item(MODE_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0);
        queue_item(MODE_RECORD, 32'h0, 8'hAA, 1'b0);
        queue_item(MODE_LOOKUP, 32'h0, 8'h55, 1'b0);
        queue_item(MODE_CLEAR,  32'h0, 8'hFF, 1'b0);
        queue_item(MODE_UNUSED, 32'hFFFF_FFFF, 8'h55, 1'b0);
        queue_item(MODE_RECORD, 32'h0000_0001, 8'h00, 1'b0);
        queue_item(MODE_RECORD, 32'h0000_0002, 8'h01, 1'b0);
        queue_item(MODE_RECORD, 32'h8000_0000, 8'h80, 1'b0);
        queue_item(MODE_RECORD, 32'h5555_5555, 8'h55, 1'b0);
        queue_item(MODE_RECORD, 32'hAAAA_AAAA, 8'hAA, 1'b0);
        queue_item(MODE_RECORD, 32'h7FFF_FFFF, 8'h7F, 1'b0);
        queue_item(MODE_RECORD, 32'hFFFF_FFFE, 8'hFE, 1'b0);
        queue_item(MODE_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0);
        queue_item(MODE_RECORD, 32'h1234_5678, 8'h5A, 1'b0);
        queue_item(MODE_LOOKUP, 32'h0000_0001, 8'h00, 1'b0);
        queue_item(MODE_CLEAR,  32'hFFFF_FFFF, 8'h00, 1'b0);
        queue_item(MODE_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0);
        queue_item(MODE_RECORD, 32'hFFFF_FFFF, 8'h3C, 1'b0);
        queue_item(MODE_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0);

        for (int i = 0; i < POOL_KEYS; i++) begin
            do key_pool[i] = $urandom; while (key_pool[i] == '0);
        end
        n = 0;
        pool_span = SLOTS;
        while (n < RANDOM_ITEMS) begin
            if (n % 100 == 0) pool_span = $urandom_range(4, POOL_KEYS);
            if (n % 150 == 149) begin
                r = $urandom_range(0, POOL_KEYS - 1);
                do key_pool[r] = $urandom; while (key_pool[r] == '0);
            end
            r = $urandom_range(0, 99);
            if (r < 3) key = '0;
            else if (r < 12) key = $urandom;
            else key = key_pool[$urandom_range(0, pool_span - 1)];
            r = $urandom_range(0, 99);
            if (r < 42) mode = MODE_RECORD;
            else if (r < 84) mode = MODE_LOOKUP;
            else if (r < 96) mode = MODE_CLEAR;
            else mode = MODE_UNUSED;
            queue_item(mode, key, 8'($urandom_range(0, 255)), (n % 300 == 0));
            n++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (pending_items.size() != 0 || in_valid || predicted_results.size() != 0);
        repeat (SETTLE) @(posedge clk);

        $display("%0d items, %0d results checked: %0d lookup hits, %0d replacements,",
                 items_accepted, results_checked, lookup_hits, replacements);
        $display("%0d clears of present keys, %0d items with key zero or unused mode",
                 present_clears, ignored_items);
        if (fail_count == 0 && predicted_results.size() == 0) begin
            $display("session_transaction_cache_lru: match");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("session_transaction_cache_lru: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/stc_pkg.sv
design/stc_mem.sv
design/stc_scan.sv
design/session_transaction_cache_lru.sv
design/stc_checker.sv
sim/testbench.sv
